@@ rtl/core/tlbpt_pkg.sv @@
// package for the page table translator: sizes, types and codes
`timescale 1ns / 1ps
package tlbpt_pkg;
   localparam int PAGE_BITS   = 8;
   localparam int FRAME_BITS  = 7;
   localparam int TLB_BITS    = 4;
   localparam int OFFSET_BITS = 8;
   localparam int STAMP_BITS  = 32;
   localparam int FRAME_COUNT = 1 << FRAME_BITS;
   localparam int TLB_DEPTH   = 1 << TLB_BITS;
   localparam int PAGE_COUNT  = 1 << PAGE_BITS;

   typedef logic [PAGE_BITS-1:0]  page_type;
   typedef logic [FRAME_BITS-1:0] frame_type;
   typedef logic [TLB_BITS-1:0]   slot_type;
   typedef logic [STAMP_BITS-1:0] stamp_type;

   // configuration register indexes
   localparam logic REG_FRAME_LIMIT = 1'b0;
   localparam logic REG_TLB_LIMIT   = 1'b1;

   // limits as effective counts, one bit wider than the index
   typedef struct packed {
      logic [FRAME_BITS:0] flim;
      logic [TLB_BITS:0]   tlim;
   } limits_type;
endpackage

@@ rtl/core/tlbpt_csr.sv @@
// configuration registers and limit clamping
`timescale 1ns / 1ps
module tlbpt_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output tlbpt_pkg::limits_type  limits
);
   import tlbpt_pkg::*;
   logic [7:0] frame_limit_ff;
   logic [4:0] tlb_limit_ff;
   logic       wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= 8'd128;
         tlb_limit_ff   <= 5'd16;
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[2])
            REG_FRAME_LIMIT: frame_limit_ff <= csr_pwdata[7:0];
            REG_TLB_LIMIT:   tlb_limit_ff   <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[2])
            REG_FRAME_LIMIT: csr_prdata = {24'd0, frame_limit_ff};
            REG_TLB_LIMIT:   csr_prdata = {27'd0, tlb_limit_ff};
            default: csr_prdata = '0;
         endcase
      end
   end

   always_comb begin
      if (frame_limit_ff == 8'd0) limits.flim = (FRAME_BITS+1)'(1);
      else if (frame_limit_ff > 8'(FRAME_COUNT)) limits.flim = (FRAME_BITS+1)'(FRAME_COUNT);
      else limits.flim = frame_limit_ff[FRAME_BITS:0];
      if (tlb_limit_ff == 5'd0) limits.tlim = (TLB_BITS+1)'(1);
      else if (tlb_limit_ff > 5'(TLB_DEPTH)) limits.tlim = (TLB_BITS+1)'(TLB_DEPTH);
      else limits.tlim = tlb_limit_ff;
   end
endmodule

@@ rtl/core/tlbpt_core.sv @@
// translation sequencer: tlb registers, page table and frame memories, lru scans
`timescale 1ns / 1ps
module tlbpt_core (
   input  logic                  clock,
   input  logic                  reset,
   input  tlbpt_pkg::limits_type limits,
   input  logic                  start,
   input  logic [15:0]           req_logical_address,
   output logic                  busy,
   output logic                  rsp_valid,
   output logic [14:0]           rsp_physical_address,
   output logic                  rsp_tlb_hit,
   output logic                  rsp_page_fault,
   output logic [6:0]            rsp_frame_number,
   output logic                  rsp_evicted_valid,
   output logic [7:0]            rsp_evicted_page
);
   import tlbpt_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PT    = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_OWNER = 3'd3;
   localparam logic [2:0] S_TSCAN = 3'd4;
   localparam logic [2:0] S_FILL  = 3'd5;

   // page table: valid bits in flops, frame in memory
   logic [PAGE_COUNT-1:0] map_valid_ff;
   frame_type             page_map_mem [PAGE_COUNT];
   page_type              frame_owner_mem [FRAME_COUNT];
   stamp_type             frame_stamp_mem [FRAME_COUNT];
   frame_type             pm_rd_ff;
   page_type              own_rd_ff;
   stamp_type             stamp_rd_ff;

   // tlb: small, every entry compared at once
   logic [TLB_DEPTH-1:0]  tlb_valid_ff;
   page_type              tlb_tag_ff   [TLB_DEPTH];
   frame_type             tlb_frame_ff [TLB_DEPTH];
   stamp_type             tlb_stamp_ff [TLB_DEPTH];

   logic [2:0]            state_ff;
   logic [15:0]           addr_ff;
   stamp_type             clock_ff;
   logic [FRAME_BITS:0]   frames_used_ff;
   logic [TLB_BITS:0]     tlb_used_ff;
   frame_type             frame_ff;
   logic [FRAME_BITS:0]   scan_ff;       // next frame whose stamp arrives
   logic                  scan_vld_ff;   // stamp_rd_ff holds frame scan_ff-1
   stamp_type             best_age_ff;
   frame_type             best_ff;
   logic                  ev_valid_ff;
   page_type              ev_page_ff;
   slot_type              tscan_ff;
   stamp_type             tbest_age_ff;
   slot_type              tbest_ff;

   page_type              page;
   logic                  accept;
   logic [TLB_DEPTH-1:0]  match;
   slot_type              hit_slot;
   logic                  hit_any;
   frame_type             pt_frame;
   frame_type             stamp_wr_addr;
   logic                  stamp_wr;
   frame_type             stamp_rd_addr;
   stamp_type             age;
   stamp_type             tage;
   slot_type              free_slot;
   logic                  free_any;

   assign accept = start && !busy;
   assign busy   = state_ff != S_IDLE;
   assign page   = addr_ff[15:8];

   always_comb begin
      match = '0;
      for (int i = 0; i < TLB_DEPTH; i++)
         match[i] = tlb_valid_ff[i] && tlb_tag_ff[i] == page;
      hit_slot = '0;
      hit_any  = 1'b0;
      for (int i = TLB_DEPTH-1; i >= 0; i--)
         if (match[i]) begin
            hit_slot = slot_type'(i);
            hit_any  = 1'b1;
         end
      free_slot = '0;
      free_any  = 1'b0;
      for (int i = TLB_DEPTH-1; i >= 0; i--)
         if (!tlb_valid_ff[i] && (TLB_BITS+1)'(i) < limits.tlim) begin
            free_slot = slot_type'(i);
            free_any  = 1'b1;
         end
   end

   assign pt_frame = hit_any ? tlb_frame_ff[hit_slot] : pm_rd_ff;
   assign age  = clock_ff - stamp_rd_ff;
   assign tage = clock_ff - tlb_stamp_ff[tscan_ff];
   assign stamp_rd_addr = scan_ff[FRAME_BITS-1:0];

   // frame stamp write: every access refreshes the frame it lands on
   always_comb begin
      stamp_wr      = 1'b0;
      stamp_wr_addr = frame_ff;
      if (state_ff == S_PT) begin
         stamp_wr      = 1'b1;
         stamp_wr_addr = pt_frame;
         if (!hit_any && !map_valid_ff[page]) stamp_wr = 1'b0;
      end else if (state_ff == S_FILL) begin
         stamp_wr = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) pm_rd_ff <= page_map_mem[req_logical_address[15:8]];
      stamp_rd_ff <= frame_stamp_mem[stamp_rd_addr];
      own_rd_ff   <= frame_owner_mem[best_ff];
      if (stamp_wr) frame_stamp_mem[stamp_wr_addr] <= clock_ff;
      if (state_ff == S_FILL) begin
         page_map_mem[page]        <= frame_ff;
         frame_owner_mem[frame_ff] <= page;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) addr_ff <= req_logical_address;
      if (reset) begin
         rsp_valid      <= 1'b0;
         state_ff       <= S_IDLE;
         map_valid_ff   <= '0;
         tlb_valid_ff   <= '0;
         clock_ff       <= '0;
         frames_used_ff <= '0;
         tlb_used_ff    <= '0;
      end else begin
         rsp_valid <= (state_ff == S_PT && (hit_any || map_valid_ff[page]))
                      || state_ff == S_FILL;
         unique case (state_ff)
            S_IDLE: if (accept) state_ff <= S_PT;
            S_PT: begin
               ev_valid_ff <= 1'b0;
               ev_page_ff  <= '0;
               if (hit_any || map_valid_ff[page]) begin
                  if (hit_any) tlb_stamp_ff[hit_slot] <= clock_ff;
                  rsp_tlb_hit          <= hit_any;
                  rsp_page_fault       <= 1'b0;
                  rsp_frame_number     <= pt_frame;
                  rsp_physical_address <= {pt_frame, addr_ff[7:0]};
                  rsp_evicted_valid    <= 1'b0;
                  rsp_evicted_page     <= '0;
                  clock_ff             <= clock_ff + 1'b1;
                  state_ff             <= S_IDLE;
               end else if (frames_used_ff < limits.flim) begin
                  frame_ff       <= frames_used_ff[FRAME_BITS-1:0];
                  frames_used_ff <= frames_used_ff + 1'b1;
                  state_ff       <= S_TSCAN;
                  tscan_ff       <= '0;
               end else begin
                  scan_ff     <= '0;
                  scan_vld_ff <= 1'b0;
                  best_ff     <= '0;
                  state_ff    <= S_SCAN;
               end
            end
            S_SCAN: begin
               // stamp of frame scan_ff-1 is in stamp_rd_ff when scan_vld_ff
               if (scan_vld_ff) begin
                  if (scan_ff == (FRAME_BITS+1)'(1) || age > best_age_ff) begin
                     best_age_ff <= age;
                     best_ff     <= frame_type'(scan_ff - 1'b1);
                  end
               end
               if (scan_vld_ff && scan_ff == limits.flim) begin
                  state_ff <= S_OWNER;
               end else begin
                  scan_ff     <= scan_ff + 1'b1;
                  scan_vld_ff <= 1'b1;
               end
            end
            S_OWNER: begin
               // own_rd_ff was read from best_ff in the previous cycle
               if (scan_vld_ff) begin
                  scan_vld_ff <= 1'b0;
               end else begin
                  frame_ff    <= best_ff;
                  ev_valid_ff <= 1'b1;
                  ev_page_ff  <= own_rd_ff;
                  map_valid_ff[own_rd_ff] <= 1'b0;
                  for (int i = 0; i < TLB_DEPTH; i++)
                     if (tlb_tag_ff[i] == own_rd_ff) tlb_valid_ff[i] <= 1'b0;
                  tscan_ff <= '0;
                  state_ff <= S_TSCAN;
               end
            end
            S_TSCAN: begin
               if (tlb_used_ff < limits.tlim) begin
                  tbest_ff    <= tlb_used_ff[TLB_BITS-1:0];
                  tlb_used_ff <= tlb_used_ff + 1'b1;
                  state_ff    <= S_FILL;
               end else if (free_any) begin
                  tbest_ff <= free_slot;
                  state_ff <= S_FILL;
               end else begin
                  if (tscan_ff == '0 || tage > tbest_age_ff) begin
                     tbest_age_ff <= tage;
                     tbest_ff     <= tscan_ff;
                  end
                  if ((TLB_BITS+1)'(tscan_ff) + 1'b1 == limits.tlim) state_ff <= S_FILL;
                  else tscan_ff <= tscan_ff + 1'b1;
               end
            end
            S_FILL: begin
               map_valid_ff[page]     <= 1'b1;
               tlb_valid_ff[tbest_ff] <= 1'b1;
               tlb_tag_ff[tbest_ff]   <= page;
               tlb_frame_ff[tbest_ff] <= frame_ff;
               tlb_stamp_ff[tbest_ff] <= clock_ff;
               rsp_tlb_hit          <= 1'b0;
               rsp_page_fault       <= 1'b1;
               rsp_frame_number     <= frame_ff;
               rsp_physical_address <= {frame_ff, addr_ff[7:0]};
               rsp_evicted_valid    <= ev_valid_ff;
               rsp_evicted_page     <= ev_page_ff;
               clock_ff             <= clock_ff + 1'b1;
               state_ff             <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_IDLE) else $error("result outside idle");
   a_fault_nohit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tlb_hit && rsp_page_fault)) else $error("hit and fault");
   a_evict_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_valid |-> rsp_page_fault) else $error("eviction without fault");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("no busy after accept");
`endif
endmodule

@@ rtl/core/tlb_page_table_translator.sv @@
// top level of the page table translator
`timescale 1ns / 1ps
// address translator with a 16-entry fully associative tlb and a page table.
// start with busy low takes one 16-bit logical_address word; one result word
// appears for one cycle on the rsp_ ports, marked by rsp_valid.
// tlb or page table hit: the result is registered from state S_PT; busy drops
// with it, so the next word is taken at the edge that ends the result cycle.
// page fault with a free frame: the request passes through S_PT, S_TSCAN and
// S_FILL; S_TSCAN runs an lru scan over the tlb when it is full with no free slot.
// page fault with eviction: a scan over frame_limit frame stamps, one
// frame-stamp memory read a cycle, then S_OWNER, S_TSCAN with its tlb lru
// scan when needed, and S_FILL (limits as clamped).
// the apb port holds frame_limit at byte 0 and tlb_limit at byte 4; write it
// only while idle.
// reset clears the page table valid bits, the tlb valid bits, the stamp clock
// and the used counters at once; no clearing pass is needed.
// the receiver cannot stall; each result is taken in its one cycle.
module tlb_page_table_translator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_logical_address,
   output logic        rsp_valid,
   output logic [14:0] rsp_physical_address,
   output logic        rsp_tlb_hit,
   output logic        rsp_page_fault,
   output logic [6:0]  rsp_frame_number,
   output logic        rsp_evicted_valid,
   output logic [7:0]  rsp_evicted_page,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tlbpt_pkg::*;
   limits_type limits;

   tlbpt_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(psel), .csr_penable(penable), .csr_pwrite(pwrite),
      .csr_paddr(paddr), .csr_pwdata(pwdata), .csr_prdata(prdata),
      .csr_pready(pready), .limits(limits)
   );

   tlbpt_core u_core (
      .clock(clock), .reset(reset), .limits(limits),
      .start(start), .req_logical_address(req_logical_address), .busy(busy),
      .rsp_valid(rsp_valid), .rsp_physical_address(rsp_physical_address),
      .rsp_tlb_hit(rsp_tlb_hit), .rsp_page_fault(rsp_page_fault),
      .rsp_frame_number(rsp_frame_number), .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_page(rsp_evicted_page)
   );
endmodule
